### sv/kis_pkg.sv
// ----------------------------------------------------------------------------
// kis_pkg: shared types and constants for the keyframe interval search core
// Item payloads, status codes and default sizing.
// ----------------------------------------------------------------------------
package kis_pkg;

  localparam int unsigned MaxKeysDefault = 256;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_ADVANCED  = 3'd3,
    ST_UNCHANGED = 3'd4,
    ST_NO_KEYS   = 3'd5
  } kis_status_t;

  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] time_value;
  } kis_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  left_index;
    logic        left_valid;
    logic [7:0]  right_index;
    logic        right_valid;
    logic [15:0] fraction;
    logic [31:0] now_time;
  } kis_out_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } kis_div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } kis_div_rsp_t;

endpackage

### sv/kis_ram.sv
// ----------------------------------------------------------------------------
// kis_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module kis_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/kis_div.sv
// ----------------------------------------------------------------------------
// kis_div: restoring divider for the interpolation fraction
// Computes (num << 16) / den truncated to 16 bits, num < den, one bit a cycle.
// ----------------------------------------------------------------------------
module kis_div
  import kis_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  kis_div_req_t req,
  output kis_div_rsp_t rsp
);

  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [15:0] quot_r, quot_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, 1'b0} - {2'b0, den_r};
    if (req.start) begin
      rem_nxt  = {1'b0, req.num};
      den_nxt  = req.den;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt  = trial[32:0];
        quot_nxt = {quot_r[14:0], 1'b1};
      end else begin
        rem_nxt  = {rem_r[31:0], 1'b0};
        quot_nxt = {quot_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

### sv/keyframe_interval_search_core.sv
// ----------------------------------------------------------------------------
// keyframe_interval_search_core: key time table with bracketing search
// Table in a single-port RAM; a sequencer scans, probes and interpolates.
// ----------------------------------------------------------------------------
// Add: scans the stored keys for a duplicate, then writes the new key.
// Advance: exits early on no keys, an unchanged time, a single key or a time
// at or past an end; else up to 8 probes at stride 128 and a divide.
// One item at a time; result held in an output register until transferred.
// Reset: synchronous, active low; clears control, counts and times; no RAM
// clearing pass, entries at or above the key count are never used.
module keyframe_interval_search_core
  import kis_pkg::*;
#(
  parameter int unsigned MaxKeys = MaxKeysDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kis_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output kis_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int unsigned AW = $clog2(MaxKeys);
  localparam int unsigned CW = $clog2(MaxKeys + 1);
  // probe sum must hold a full 8-bit stride on top of any position
  localparam int unsigned PW = ((CW > 8) ? CW : 8) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_RD, S_ADD_CMP, S_ADV, S_RD_FIRST, S_CHK_FIRST,
    S_CHK_LAST, S_PROBE_RD, S_PROBE_CMP, S_POS_RD, S_POS_CMP,
    S_NEXT_CMP, S_DIV, S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, idx_r, idx_nxt;
  logic [31:0] first_r, first_nxt, last_r, last_nxt, cur_r, cur_nxt;
  logic [31:0] prev_r, prev_nxt, tv_r, tv_nxt, tl_r, tl_nxt;
  logic [AW-1:0] lidx_r, lidx_nxt, ridx_r, ridx_nxt, pos_r, pos_nxt;
  logic        lval_r, lval_nxt, rval_r, rval_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic [7:0]  step_r, stride_r, stride_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic        we;
  logic [AW-1:0] addr;
  logic [31:0] rdata;
  logic [32:0] sum;
  logic [31:0] sat;
  logic [PW-1:0] probe;
  kis_div_req_t dreq;
  kis_div_rsp_t drsp;

  kis_ram #(.Width(32), .Depth(MaxKeys)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(tv_r), .rdata(rdata)
  );

  kis_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; idx_nxt = idx_r;
    first_nxt = first_r; last_nxt = last_r; cur_nxt = cur_r; prev_nxt = prev_r;
    tv_nxt = tv_r; tl_nxt = tl_r; lidx_nxt = lidx_r; ridx_nxt = ridx_r;
    pos_nxt = pos_r; lval_nxt = lval_r; rval_nxt = rval_r; frac_nxt = frac_r;
    stride_nxt = stride_r; stat_nxt = stat_r; ovalid_nxt = ovalid_r;
    we = 1'b0; addr = idx_r[AW-1:0];
    dreq.start = 1'b0; dreq.num = cur_r - tl_r; dreq.den = rdata - tl_r;
    sum = {1'b0, cur_r} + {1'b0, tv_r};
    sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    probe = PW'(pos_r) + PW'(stride_r);
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tv_nxt = in_data.time_value;
          idx_nxt = '0;
          if (in_data.opcode == OP_ADD) begin
            if (count_r == '0) begin
              first_nxt = in_data.time_value;
              last_nxt  = in_data.time_value;
            end
            state_nxt = S_ADD_RD;
          end else begin
            state_nxt = S_ADV;
          end
        end
      end
      S_ADD_RD: begin
        if (idx_r == count_r) begin
          if (count_r == CW'(MaxKeys)) begin
            stat_nxt = ST_FULL;
          end else begin
            we = 1'b1;
            count_nxt = count_r + 1'b1;
            if (tv_r < first_r) first_nxt = tv_r;
            if (tv_r > last_r) last_nxt = tv_r;
            stat_nxt = ST_ADDED;
          end
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_ADD_CMP;
        end
      end
      S_ADD_CMP: begin
        if (rdata == tv_r) begin
          stat_nxt = ST_DUPLICATE;
          state_nxt = S_OUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_ADD_RD;
        end
      end
      S_ADV: begin
        if (count_r == '0) begin
          stat_nxt = ST_NO_KEYS;
          state_nxt = S_OUT;
        end else begin
          if (sat >= last_r) cur_nxt = sat - (last_r - first_r);
          else cur_nxt = sat;
          state_nxt = S_RD_FIRST;
        end
      end
      S_RD_FIRST: begin
        if (cur_r == prev_r) begin
          stat_nxt = ST_UNCHANGED;
          state_nxt = S_OUT;
        end else begin
          prev_nxt = cur_r;
          stat_nxt = ST_ADVANCED;
          if (count_r == CW'(1)) begin
            lidx_nxt = '0; lval_nxt = 1'b1; ridx_nxt = '0; rval_nxt = 1'b1;
            state_nxt = S_OUT;
          end else begin
            addr = '0;
            state_nxt = S_CHK_FIRST;
          end
        end
      end
      S_CHK_FIRST: begin
        if (rdata >= cur_r) begin
          lidx_nxt = '0; lval_nxt = 1'b1; ridx_nxt = '0; rval_nxt = 1'b0;
          state_nxt = S_OUT;
        end else begin
          addr = AW'(count_r - 1'b1);
          state_nxt = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        if (rdata <= cur_r) begin
          lidx_nxt = '0; lval_nxt = 1'b0;
          ridx_nxt = AW'(count_r - 1'b1); rval_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          pos_nxt = '0;
          stride_nxt = step_r;
          state_nxt = S_PROBE_RD;
        end
      end
      S_PROBE_RD: begin
        if (stride_r == '0) begin
          addr = pos_r;
          state_nxt = S_POS_CMP;
        end else if (probe < PW'(count_r)) begin
          addr = AW'(probe);
          state_nxt = S_PROBE_CMP;
        end else begin
          stride_nxt = stride_r >> 1;
        end
      end
      S_PROBE_CMP: begin
        if (rdata <= cur_r) pos_nxt = AW'(probe);
        stride_nxt = stride_r >> 1;
        state_nxt = S_PROBE_RD;
      end
      S_POS_CMP: begin
        tl_nxt = rdata;
        lidx_nxt = pos_r; lval_nxt = 1'b1; rval_nxt = 1'b1;
        if (rdata == cur_r) begin
          ridx_nxt = pos_r;
          state_nxt = S_OUT;
        end else begin
          ridx_nxt = pos_r + 1'b1;
          addr = pos_r + 1'b1;
          state_nxt = S_NEXT_CMP;
        end
      end
      S_NEXT_CMP: begin
        if (rdata <= cur_r || tl_r >= cur_r) begin
          frac_nxt = 16'hFFFF;
          state_nxt = S_OUT;
        end else begin
          dreq.start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          frac_nxt = drsp.quot;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; first_r <= '0; last_r <= '0;
      cur_r <= '0; prev_r <= '1; lidx_r <= '0; lval_r <= 1'b1;
      ridx_r <= '0; rval_r <= 1'b1; frac_r <= '0; step_r <= 8'd128;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; first_r <= first_nxt;
      last_r <= last_nxt; cur_r <= cur_nxt; prev_r <= prev_nxt;
      lidx_r <= lidx_nxt; lval_r <= lval_nxt; ridx_r <= ridx_nxt;
      rval_r <= rval_nxt; frac_r <= frac_nxt; ovalid_r <= ovalid_nxt;
      if (cfg_valid) step_r <= cfg_data;
      if (state_r == S_OUT && state_nxt == S_IDLE) begin
        out_data.status      <= stat_r;
        out_data.left_index  <= 8'(lidx_r);
        out_data.left_valid  <= lval_r;
        out_data.right_index <= 8'(ridx_r);
        out_data.right_valid <= rval_r;
        out_data.fraction    <= frac_r;
        out_data.now_time    <= cur_r;
      end
    end
    idx_r <= idx_nxt; tv_r <= tv_nxt; tl_r <= tl_nxt; pos_r <= pos_nxt;
    stride_r <= stride_nxt; stat_r <= stat_nxt;
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MaxKeys)) else $error("key count overflow");
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> count_r < CW'(MaxKeys)) else $error("write to full table");
  a_first_le_last: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 |-> first_r <= last_r) else $error("first above last");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |=> state_r == S_DIV) else $error("divider start lost");

endmodule
